// ===== sv/mbh_pkg.sv =====
// Package for the MurmurHash2 byte hasher: constants, register indexes and state type.
`timescale 1ns / 1ps

package mbh_pkg;

  // Mixing multiplier and shift amounts
  localparam logic [31:0] MIX_MUL     = 32'h5bd1e995;
  localparam int          MIX_SHIFT   = 24;
  localparam int          FIN_SHIFT_A = 13;
  localparam int          FIN_SHIFT_B = 15;

  // Reset value of the seed register
  localparam logic [31:0] SEED_RESET  = 32'h31415926;

  // Length field handling: only the low LENGTH_BITS bits enter the seed XOR
  localparam int          LENGTH_BITS = 16;
  localparam int          LEN_W       = 16;
  localparam logic [LEN_W-1:0] LEN_MASK =
      (LENGTH_BITS >= LEN_W) ? {LEN_W{1'b1}} : LEN_W'((64'd1 << LENGTH_BITS) - 64'd1);

  // ASCII upper-case range and case offset
  localparam logic [7:0] ASCII_UP_LO = 8'h41;
  localparam logic [7:0] ASCII_UP_HI = 8'h5A;
  localparam logic [7:0] ASCII_CASE  = 8'h20;

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_HASH_SEED = 1'b0,
    REG_LOWERCASE = 1'b1
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_K1,
    ST_K2,
    ST_K3,
    ST_K4,
    ST_TAIL,
    ST_TAIL2,
    ST_FIN1,
    ST_FIN2
  } seq_state_e;

endpackage

// ===== sv/murmur2_byte_hash.sv =====
// Top level of the MurmurHash2 (32-bit) byte-stream hasher.
`timescale 1ns / 1ps

// MurmurHash2 over a byte stream, one byte per transfer. A byte that does not
// complete a 32-bit word is stored without leaving idle; the byte that completes
// a word runs the word mix (K1 to K4), three passes through the single shared
// constant multiplier, whose product is registered. A last byte adds the final
// mix (FIN1, FIN2), after TAIL and TAIL2 for a tail fold; FIN2 waits for the
// output register to be free. The next message may start while the hash still
// waits at the output. The input stalls while a word mix, fold or final mix runs.
module murmur2_byte_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic [15:0] message_length_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] hash_value_o
);

  mbh_pkg::seq_state_e state_q, state_d;

  logic [31:0] seed_q;
  logic        lc_q;
  logic [31:0] h_q, h_d;
  logic [23:0] pw_q, pw_d;
  logic [1:0]  pos_q, pos_d;
  logic [31:0] k_q, k_d;
  logic        last_q, last_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_hash_q, out_hash_d;

  logic [31:0] mul_op;
  logic [31:0] mul_p;

  logic        in_xfer;
  logic [15:0] len_m;
  logic        take_byte;
  logic [7:0]  byte_lc;
  logic [31:0] base_h;
  logic [23:0] base_pw;
  logic [1:0]  base_pos;
  logic [31:0] k_shr;
  logic [31:0] fin_res;
  logic        out_free;

  // Shared multiplier
  mbh_mul u_mul (
    .clk_i     (clk_i),
    .operand_i (mul_op),
    .product_o (mul_p)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= mbh_pkg::SEED_RESET;
      lc_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (mbh_pkg::reg_idx_e'(cfg_index_i))
        mbh_pkg::REG_HASH_SEED: seed_q <= cfg_wdata_i;
        mbh_pkg::REG_LOWERCASE: lc_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign in_stall_o  = (state_q != mbh_pkg::ST_IDLE);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign hash_value_o = out_hash_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Byte preparation
  assign len_m     = message_length_i & mbh_pkg::LEN_MASK;
  assign take_byte = !(first_byte_i && last_byte_i && (len_m == 16'd0));
  assign byte_lc   = (lc_q && data_byte_i >= mbh_pkg::ASCII_UP_LO &&
                      data_byte_i <= mbh_pkg::ASCII_UP_HI)
                     ? data_byte_i + mbh_pkg::ASCII_CASE : data_byte_i;
  assign base_h    = first_byte_i ? (seed_q ^ {16'd0, len_m}) : h_q;
  assign base_pw   = first_byte_i ? 24'd0 : pw_q;
  assign base_pos  = first_byte_i ? 2'd0 : pos_q;

  // Intermediate shifts on the registered product
  assign k_shr   = mul_p ^ (mul_p >> mbh_pkg::MIX_SHIFT);
  assign fin_res = mul_p ^ (mul_p >> mbh_pkg::FIN_SHIFT_B);

  // Sequencer: next state, datapath updates and multiplier operand
  always_comb begin
    state_d     = state_q;
    h_d         = h_q;
    pw_d        = pw_q;
    pos_d       = pos_q;
    k_d         = k_q;
    last_d      = last_q;
    out_hash_d  = out_hash_q;
    out_valid_d = out_valid_q && out_stall_i;
    mul_op      = h_q;

    unique case (state_q)
      mbh_pkg::ST_IDLE: begin
        if (in_xfer) begin
          h_d    = base_h;
          pw_d   = base_pw;
          pos_d  = base_pos;
          last_d = last_byte_i;
          if (take_byte && base_pos == 2'd3) begin
            k_d     = {byte_lc, base_pw};
            state_d = mbh_pkg::ST_K1;
          end else if (take_byte) begin
            pw_d  = base_pw | (24'(byte_lc) << {base_pos, 3'b000});
            pos_d = base_pos + 2'd1;
            if (last_byte_i) begin
              state_d = mbh_pkg::ST_TAIL;
            end
          end else begin
            // empty message: straight to the final mix
            state_d = mbh_pkg::ST_FIN1;
          end
        end
      end
      mbh_pkg::ST_K1: begin
        mul_op  = k_q;
        state_d = mbh_pkg::ST_K2;
      end
      mbh_pkg::ST_K2: begin
        mul_op  = k_shr;
        state_d = mbh_pkg::ST_K3;
      end
      mbh_pkg::ST_K3: begin
        k_d     = mul_p;
        mul_op  = h_q;
        state_d = mbh_pkg::ST_K4;
      end
      mbh_pkg::ST_K4: begin
        h_d     = mul_p ^ k_q;
        pw_d    = 24'd0;
        pos_d   = 2'd0;
        state_d = last_q ? mbh_pkg::ST_FIN1 : mbh_pkg::ST_IDLE;
      end
      mbh_pkg::ST_TAIL: begin
        // fold the held tail bytes
        mul_op  = h_q ^ {8'd0, pw_q};
        state_d = mbh_pkg::ST_TAIL2;
      end
      mbh_pkg::ST_TAIL2: begin
        h_d     = mul_p;
        state_d = mbh_pkg::ST_FIN1;
      end
      mbh_pkg::ST_FIN1: begin
        mul_op  = h_q ^ (h_q >> mbh_pkg::FIN_SHIFT_A);
        state_d = mbh_pkg::ST_FIN2;
      end
      mbh_pkg::ST_FIN2: begin
        // product holds until the output register is free
        mul_op = h_q ^ (h_q >> mbh_pkg::FIN_SHIFT_A);
        if (out_free) begin
          out_hash_d  = fin_res;
          out_valid_d = 1'b1;
          h_d         = 32'd0;
          pw_d        = 24'd0;
          pos_d       = 2'd0;
          state_d     = mbh_pkg::ST_IDLE;
        end
      end
      default: state_d = mbh_pkg::ST_IDLE;
    endcase
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbh_pkg::ST_IDLE;
      h_q         <= 32'd0;
      pw_q        <= 24'd0;
      pos_q       <= 2'd0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      h_q         <= h_d;
      pw_q        <= pw_d;
      pos_q       <= pos_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    out_hash_q <= out_hash_d;
  end

endmodule

// ===== sv/mbh_mul.sv =====
// Shared multiply-by-constant unit with registered product.
`timescale 1ns / 1ps

module mbh_mul (
  input  logic        clk_i,
  input  logic [31:0] operand_i,
  output logic [31:0] product_o
);

  logic [31:0] product_d;
  logic [31:0] product_q;

  // Low 32 bits of operand times the mixing constant
  assign product_d = operand_i * mbh_pkg::MIX_MUL;

  always_ff @(posedge clk_i) begin
    product_q <= product_d;
  end

  assign product_o = product_q;

endmodule

// ===== bench/mbh_checker.sv =====
// Checker for the byte hasher: follows both channels, predicts each hash and compares it.
`timescale 1ns / 1ps

module mbh_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration port, observed
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [31:0] cfg_wdata_i,
  // input channel, observed
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  input  logic [15:0] message_length_i,
  // output channel, observed
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [31:0] hash_value_i,
  // status for the bench top
  output int          fail_count_o,
  output int          pending_o
);

  // Shadow copy of the configuration
  logic [31:0] seed_q;
  logic        lower_q;

  // Predicted hashing state
  logic [31:0] acc_hash;
  logic [23:0] tail_bytes;
  logic [1:0]  tail_count;

  // Hashes still owed by the block, oldest first
  logic [31:0] hash_queue[$];
  logic [31:0] oldest_hash;

  // One 32-bit word folded into the running hash
  function automatic logic [31:0] mix_word(input logic [31:0] h, input logic [31:0] k);
    logic [31:0] m;
    m = k * mbh_pkg::MIX_MUL;
    m = m ^ (m >> mbh_pkg::MIX_SHIFT);
    m = m * mbh_pkg::MIX_MUL;
    return (h * mbh_pkg::MIX_MUL) ^ m;
  endfunction

  // Closing avalanche
  function automatic logic [31:0] final_mix(input logic [31:0] h);
    logic [31:0] f;
    f = h ^ (h >> mbh_pkg::FIN_SHIFT_A);
    f = f * mbh_pkg::MIX_MUL;
    return f ^ (f >> mbh_pkg::FIN_SHIFT_B);
  endfunction

  // Advance the prediction by one accepted byte transfer
  task automatic absorb_byte(input logic [7:0] b, input logic first, input logic last,
                             input logic [15:0] len);
    logic [7:0]  c;
    logic [15:0] used_len;
    logic [31:0] h;
    logic        take;
    c        = b;
    take     = 1'b1;
    used_len = len & mbh_pkg::LEN_MASK;
    // a first mark restarts, dropping whatever message was open
    if (first) begin
      acc_hash   = seed_q ^ {16'd0, used_len};
      tail_bytes = '0;
      tail_count = '0;
      // empty message: byte carries nothing
      if (last && used_len == '0) take = 1'b0;
    end
    if (take) begin
      if (lower_q && c >= mbh_pkg::ASCII_UP_LO && c <= mbh_pkg::ASCII_UP_HI)
        c = c + mbh_pkg::ASCII_CASE;
      if (tail_count == 2'd3) begin
        acc_hash   = mix_word(acc_hash, {c, tail_bytes});
        tail_bytes = '0;
        tail_count = '0;
      end else begin
        tail_bytes = tail_bytes | (24'(c) << (8 * tail_count));
        tail_count = tail_count + 2'd1;
      end
    end
    // last mark: fold the tail, finish, and clear for the next message
    if (last) begin
      h = acc_hash;
      if (tail_count != 2'd0) h = (h ^ {8'd0, tail_bytes}) * mbh_pkg::MIX_MUL;
      hash_queue.push_back(final_mix(h));
      acc_hash   = '0;
      tail_bytes = '0;
      tail_count = '0;
    end
  endtask

  // Sample every channel at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q       = mbh_pkg::SEED_RESET;
      lower_q      = 1'b0;
      acc_hash     = '0;
      tail_bytes   = '0;
      tail_count   = '0;
      hash_queue.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (mbh_pkg::reg_idx_e'(cfg_index_i))
          mbh_pkg::REG_HASH_SEED: seed_q  = cfg_wdata_i;
          mbh_pkg::REG_LOWERCASE: lower_q = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i)
        absorb_byte(data_byte_i, first_byte_i, last_byte_i, message_length_i);
      if (out_valid_i && !out_stall_i) begin
        if (hash_queue.size() == 0) begin
          $display("%0t: unexpected hash_value transfer, expected none, actual %08h",
                   $time, hash_value_i);
          fail_count_o = fail_count_o + 1;
        end else begin
          oldest_hash = hash_queue.pop_front();
          if (hash_value_i !== oldest_hash) begin
            $display("%0t: hash_value mismatch, expected %08h, actual %08h",
                     $time, oldest_hash, hash_value_i);
            fail_count_o = fail_count_o + 1;
          end
        end
      end
      pending_o = hash_queue.size();
    end
  end

endmodule

// ===== bench/tb_top.sv =====
// Bench top for the byte hasher: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module tb_top;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic        last_byte;
  logic [15:0] message_length;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] hash_value;
  int          fail_count;
  int          pending;

  // Random idling on both sides; cleared for one long stretch
  bit          idle_en = 1'b1;
  int          item_count = 0;

  murmur2_byte_hash uut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (data_byte),
    .first_byte_i     (first_byte),
    .last_byte_i      (last_byte),
    .message_length_i (message_length),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .hash_value_o     (hash_value)
  );

  mbh_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .data_byte_i      (data_byte),
    .first_byte_i     (first_byte),
    .last_byte_i      (last_byte),
    .message_length_i (message_length),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .hash_value_i     (hash_value),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  // 8 ns clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // Receiver side: random back-pressure on the hash output
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= rst_n && idle_en && ($urandom_range(0, 99) < 36);
    end
  end

  // One byte transfer; entered and left at a falling edge
  task automatic send_item(input logic [7:0] b, input logic first, input logic last,
                           input logic [15:0] len);
    if (idle_en) begin
      while ($urandom_range(0, 99) < 36) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid       <= 1'b1;
    data_byte      <= b;
    first_byte     <= first;
    last_byte      <= last;
    message_length <= len;
    do @(posedge clk); while (in_stall);
    item_count++;
    @(negedge clk);
  endtask

  // Configuration write, only while idle
  task automatic write_reg(input mbh_pkg::reg_idx_e idx, input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Drain all owed hashes, then let any word mix in flight finish
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Byte source biased towards the upper-case boundaries
  function automatic logic [7:0] pick_byte();
    if ($urandom_range(0, 9) < 3) return 8'($urandom_range(8'h40, 8'h5B));
    return 8'($urandom_range(0, 255));
  endfunction

  // Well-formed message; zero bytes gives the empty-message form
  task automatic send_message(input int nbytes, input logic [15:0] decl_len);
    int i;
    if (nbytes == 0) begin
      send_item(pick_byte(), 1'b1, 1'b1, 16'd0);
    end else begin
      for (i = 0; i < nbytes; i++)
        send_item(pick_byte(), i == 0, i == nbytes - 1, decl_len);
    end
  endtask

  // One random group: mostly messages, some abandoned starts and stray bytes
  task automatic random_group();
    int r;
    int n;
    int i;
    r = $urandom_range(0, 99);
    if (r < 80) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      if (n == 0) send_message(0, 16'd0);
      else if ($urandom_range(0, 4) == 0) send_message(n, 16'($urandom));
      else send_message(n, 16'(n));
    end else if (r < 90) begin
      // started but never closed; the next first mark drops it
      n = $urandom_range(1, 7);
      for (i = 0; i < n; i++) send_item(pick_byte(), i == 0, 1'b0, 16'($urandom));
    end else begin
      send_item(pick_byte(), 1'b0, 1'($urandom_range(0, 1)), 16'($urandom));
    end
  endtask

  // Stimulus and verdict
  initial begin
    int phase;
    int target;
    int wait_cycles;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = mbh_pkg::REG_HASH_SEED;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    data_byte      = '0;
    first_byte     = 1'b0;
    last_byte      = 1'b0;
    message_length = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty message, then one-byte messages at the length extremes
    send_item(8'hAB, 1'b1, 1'b1, 16'd0);
    send_item(8'hFF, 1'b1, 1'b1, 16'd1);
    send_item(8'h00, 1'b1, 1'b1, 16'hFFFF);
    // exactly one word, no tail
    send_item(8'h41, 1'b1, 1'b0, 16'd4);
    send_item(8'h42, 1'b0, 1'b0, 16'd4);
    send_item(8'h43, 1'b0, 1'b0, 16'd4);
    send_item(8'h44, 1'b0, 1'b1, 16'd4);
    // declared length disagrees with the bytes sent
    send_item(8'h80, 1'b1, 1'b0, 16'd2);
    send_item(8'h7F, 1'b0, 1'b0, 16'd0);
    send_item(8'h01, 1'b0, 1'b0, 16'd0);
    send_item(8'hFE, 1'b0, 1'b0, 16'd0);
    send_item(8'h55, 1'b0, 1'b1, 16'd0);
    // bytes with no first mark carry on from the cleared state
    send_item(8'h12, 1'b0, 1'b0, 16'h5555);
    send_item(8'h34, 1'b0, 1'b0, 16'h0000);
    send_item(8'h56, 1'b0, 1'b1, 16'hAAAA);
    // a first mark mid-message restarts
    send_item(8'h11, 1'b1, 1'b0, 16'd3);
    send_item(8'h22, 1'b0, 1'b0, 16'd0);
    send_item(8'h33, 1'b1, 1'b0, 16'd2);
    send_item(8'h44, 1'b0, 1'b1, 16'd0);
    // zero declared length but real bytes
    send_item(8'h61, 1'b1, 1'b0, 16'd0);
    send_item(8'h62, 1'b0, 1'b1, 16'd0);
    // lower-casing at the edges of A..Z
    wait_idle();
    write_reg(mbh_pkg::REG_LOWERCASE, 32'd1);
    send_item(8'h41, 1'b1, 1'b0, 16'd5);
    send_item(8'h5A, 1'b0, 1'b0, 16'd5);
    send_item(8'h40, 1'b0, 1'b0, 16'd5);
    send_item(8'h5B, 1'b0, 1'b0, 16'd5);
    send_item(8'h7A, 1'b0, 1'b1, 16'd5);

    // random phases over several settings
    for (phase = 0; phase < 6; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          write_reg(mbh_pkg::REG_HASH_SEED, mbh_pkg::SEED_RESET);
          write_reg(mbh_pkg::REG_LOWERCASE, 32'd0);
        end
        1: begin
          write_reg(mbh_pkg::REG_HASH_SEED, 32'h0000_0000);
          write_reg(mbh_pkg::REG_LOWERCASE, 32'd1);
        end
        2: begin
          write_reg(mbh_pkg::REG_HASH_SEED, 32'hFFFF_FFFF);
          write_reg(mbh_pkg::REG_LOWERCASE, 32'd0);
          idle_en = 1'b0;
        end
        3: begin
          idle_en = 1'b1;
          write_reg(mbh_pkg::REG_HASH_SEED, $urandom);
          write_reg(mbh_pkg::REG_LOWERCASE, 32'd1);
        end
        default: begin
          write_reg(mbh_pkg::REG_HASH_SEED, $urandom);
          write_reg(mbh_pkg::REG_LOWERCASE, 32'($urandom_range(0, 1)));
        end
      endcase
      target = item_count + 225;
      while (item_count < target) random_group();
    end

    // drain and decide
    in_valid <= 1'b0;
    for (wait_cycles = 0; wait_cycles < 20000 && pending != 0; wait_cycles++)
      @(posedge clk);
    repeat (30) @(posedge clk);
    if (pending != 0)
      $display("%0t: %0d hash transfers never arrived, expected 0 pending", $time, pending);
    if (fail_count == 0 && pending == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
